@@ design/hctg_pkg.sv @@
package hctg_pkg;

	localparam int LEVEL_W = 5;
	localparam int POS_W   = 4;

	localparam logic [POS_W-1:0] PROD_LEN = 4'd11;

	localparam logic [1:0] SYM_F     = 2'd0;
	localparam logic [1:0] SYM_PLUS  = 2'd1;
	localparam logic [1:0] SYM_MINUS = 2'd2;
	localparam logic [1:0] SYM_NONE  = 2'd3;

	localparam logic [2:0] ITEM_F      = 3'd0;
	localparam logic [2:0] ITEM_PLUS   = 3'd1;
	localparam logic [2:0] ITEM_MINUS  = 3'd2;
	localparam logic [2:0] ITEM_NONE   = 3'd3;
	localparam logic [2:0] ITEM_CALL_L = 3'd4;
	localparam logic [2:0] ITEM_CALL_R = 3'd5;

	localparam logic KIND_LEFT  = 1'b0;
	localparam logic KIND_RIGHT = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [POS_W-1:0] pos;
	} frame_t;

	localparam int FRAME_W = $bits(frame_t);

	// The right production is the left one with turns and call kinds swapped.
	function automatic logic [2:0] prod_item(input logic kind, input logic [POS_W-1:0] pos);
		logic [2:0] it;
		logic [2:0] res;
		case (pos)
			4'd0:    it = ITEM_MINUS;
			4'd1:    it = ITEM_CALL_R;
			4'd2:    it = ITEM_F;
			4'd3:    it = ITEM_PLUS;
			4'd4:    it = ITEM_CALL_L;
			4'd5:    it = ITEM_F;
			4'd6:    it = ITEM_CALL_L;
			4'd7:    it = ITEM_PLUS;
			4'd8:    it = ITEM_F;
			4'd9:    it = ITEM_CALL_R;
			4'd10:   it = ITEM_MINUS;
			default: it = ITEM_NONE;
		endcase
		res = it;
		if (kind == KIND_RIGHT) begin
			case (it)
				ITEM_MINUS:  res = ITEM_PLUS;
				ITEM_PLUS:   res = ITEM_MINUS;
				ITEM_CALL_L: res = ITEM_CALL_R;
				ITEM_CALL_R: res = ITEM_CALL_L;
				default:     res = it;
			endcase
		end
		return res;
	endfunction

endpackage

@@ design/hctg_ram.sv @@
module hctg_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/hilbert_curve_turtle_generator_unit.sv @@
// Hilbert curve turtle command source.
//
// Each item on the s_ side requests one symbol. Bit 0 of s_tdata set starts
// a new curve at the order held in the configuration register, clear asks
// for the next symbol of the running curve. Each item yields exactly one
// item on the m_ side: the symbol in m_tdata[1:0] (forward, right, left or
// none) and m_tlast on the final symbol of the curve. The order is written
// through cfg_valid/cfg_data only while the block is idle, which the user
// must ensure (unenforced); orders above MAX_LEVEL are clamped at curve start.
//
// The stack of frames lives in a one-port-write, one-port-read memory; the
// top frame is held in a register. A symbol that follows directly from the
// top frame leaves through the output register, and a new item is taken in
// the cycle a symbol is produced, so the rate is one item per cycle along
// such runs while m_tready does not stall. Each skipped or pushed call takes
// a step of its own, each finished frame a pop and then a memory read, and a
// none result passes through a state of its own. A stall on m_tready holds
// the symbol step and stops further items; the waiting result stays in the
// output register. Reset leaves no curve running and the order at one.
module hilbert_curve_turtle_generator_unit #(
	parameter int MAX_LEVEL = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [0] restart, [7:1] zero
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [1:0] symbol, [7:2] zero
	output logic       m_tlast,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [4:0] cfg_data
);

	localparam int AW = (MAX_LEVEL > 1) ? $clog2(MAX_LEVEL) : 1;
	localparam int DW = $clog2(MAX_LEVEL + 1);
	localparam int LW = hctg_pkg::LEVEL_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;
	localparam logic [1:0] ST_NONE = 2'd3;

	logic [1:0]           state_q, state_nxt;
	hctg_pkg::frame_t     top_q, top_nxt;
	logic [DW-1:0]        depth_q, depth_nxt;
	logic                 finished_q, finished_nxt;
	logic [LW-1:0]        active_q, active_nxt;
	logic [LW-1:0]        level_q;
	logic                 out_valid_q;
	logic [1:0]           out_sym_q;
	logic                 out_last_q;

	logic                 slot_free;
	logic                 emit;
	logic [1:0]           emit_sym;
	logic                 emit_last;
	logic [2:0]           item;
	logic [3:0]           pos_inc;
	logic [DW-1:0]        top_idx;
	logic [DW:0]          below_idx;
	logic                 mem_we;
	hctg_pkg::frame_t     mem_wdata;
	logic [hctg_pkg::FRAME_W-1:0] mem_rdata;
	logic                 accept;
	logic [LW-1:0]        level_sat;

	assign slot_free = !out_valid_q || m_tready;
	assign item      = hctg_pkg::prod_item(top_q.kind, top_q.pos);
	assign pos_inc   = top_q.pos + 4'd1;
	assign top_idx   = depth_q - DW'(1);
	assign below_idx = {1'b0, depth_q} - (DW + 1)'(2);
	assign level_sat = (level_q > LW'(MAX_LEVEL)) ? LW'(MAX_LEVEL) : level_q;
	assign mem_wdata = '{kind: top_q.kind, pos: pos_inc};

	hctg_ram #(
		.WIDTH(hctg_pkg::FRAME_W),
		.DEPTH(MAX_LEVEL)
	) u_stack (
		.clk  (clk),
		.we   (mem_we),
		.waddr(top_idx[AW-1:0]),
		.wdata(mem_wdata),
		.raddr(below_idx[AW-1:0]),
		.rdata(mem_rdata)
	);

	always_comb begin
		state_nxt    = state_q;
		top_nxt      = top_q;
		depth_nxt    = depth_q;
		finished_nxt = finished_q;
		active_nxt   = active_q;
		emit         = 1'b0;
		emit_sym     = hctg_pkg::SYM_NONE;
		emit_last    = 1'b0;
		mem_we       = 1'b0;

		case (state_q)
			ST_RUN: begin
				if (top_q.pos >= hctg_pkg::PROD_LEN) begin
					if (depth_q == DW'(1)) begin
						if (slot_free) begin
							emit         = 1'b1;
							depth_nxt    = '0;
							finished_nxt = 1'b1;
							state_nxt    = ST_IDLE;
						end
					end else begin
						depth_nxt = depth_q - DW'(1);
						state_nxt = ST_LOAD;
					end
				end else if (item == hctg_pkg::ITEM_CALL_L || item == hctg_pkg::ITEM_CALL_R) begin
					top_nxt.pos = pos_inc;
					if (LW'(depth_q) < active_q) begin
						mem_we       = 1'b1;
						top_nxt.kind = (item == hctg_pkg::ITEM_CALL_R) ? hctg_pkg::KIND_RIGHT
							: hctg_pkg::KIND_LEFT;
						top_nxt.pos  = '0;
						depth_nxt    = depth_q + DW'(1);
					end
				end else if (slot_free) begin
					emit        = 1'b1;
					emit_sym    = item[1:0];
					top_nxt.pos = pos_inc;
					state_nxt   = ST_IDLE;
					if (depth_q == DW'(1) && pos_inc >= hctg_pkg::PROD_LEN) begin
						emit_last    = 1'b1;
						depth_nxt    = '0;
						finished_nxt = 1'b1;
					end
				end
			end
			ST_LOAD: begin
				top_nxt   = hctg_pkg::frame_t'(mem_rdata);
				state_nxt = ST_RUN;
			end
			ST_NONE: begin
				if (slot_free) begin
					emit      = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
			end
		endcase

		accept = s_tvalid && ((state_q == ST_IDLE) || emit);
		if (accept) begin
			if (s_tdata[0]) begin
				active_nxt = level_sat;
				depth_nxt  = '0;
				if (level_sat == '0) begin
					finished_nxt = 1'b1;
					state_nxt    = ST_NONE;
				end else begin
					finished_nxt = 1'b0;
					depth_nxt    = DW'(1);
					top_nxt      = '{kind: hctg_pkg::KIND_LEFT, pos: '0};
					state_nxt    = ST_RUN;
				end
			end else begin
				state_nxt = finished_nxt ? ST_NONE : ST_RUN;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE) || emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			depth_q     <= '0;
			finished_q  <= 1'b1;
			active_q    <= '0;
			level_q     <= LW'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_nxt;
			depth_q    <= depth_nxt;
			finished_q <= finished_nxt;
			active_q   <= active_nxt;
			if (cfg_valid) begin
				level_q <= cfg_data;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_nxt;
		if (emit) begin
			out_sym_q  <= emit_sym;
			out_last_q <= emit_last;
		end
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {6'd0, out_sym_q};
	assign m_tlast   = out_last_q;

endmodule

@@ design/hctg_checker.sv @@
module hctg_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// A waiting result item holds until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result item changed while stalled");

	// Every curve closes with a left turn.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[1:0] == hctg_pkg::SYM_MINUS)
		else $error("final symbol is not a left turn");

	// An empty result is never the end of a curve.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == hctg_pkg::SYM_NONE |-> !m_tlast)
		else $error("none symbol marked as last");

endmodule

bind hilbert_curve_turtle_generator_unit hctg_checker u_hctg_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
